FILE: design/vbd_pkg.sv
// ----------------------------------------------------------------------------
// vbd_pkg: shared types and widths for the view basis block
// Beat types of both channels and the datapath widths of the root lanes.
// ----------------------------------------------------------------------------
`default_nettype none

package vbd_pkg;

    localparam int ROOT_BITS = 16;
    localparam int MAG_W     = 32;
    localparam int SQ_W      = 64;
    localparam int REM_W     = 96;
    localparam int PROD_W    = 80;
    localparam int FRONT_STAGES = 4;
    localparam int NUM_STAGES   = FRONT_STAGES + ROOT_BITS + 1;

    localparam logic REG_INVERT_UP = 1'b0;

    typedef struct packed {
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
    } dir_t;

    typedef struct packed {
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic signed [15:0] right_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
    } basis_t;

endpackage

`default_nettype wire

FILE: design/vbd_root_lane.sv
// ----------------------------------------------------------------------------
// vbd_root_lane: pipelined scaled ratio root
// Finds the largest t with t*t*n <= 2^30*m*m, one bit of t per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vbd_root_lane
(
    input  wire logic                         clk,
    input  wire logic [vbd_pkg::ROOT_BITS-1:0] en,
    input  wire logic [vbd_pkg::SQ_W-1:0]      sq,
    input  wire logic [vbd_pkg::SQ_W-1:0]      nrm,
    input  wire logic                         neg,
    input  wire logic                         mzero,
    output logic      [vbd_pkg::ROOT_BITS-1:0] root,
    output logic                              root_neg,
    output logic                              root_zero
);
    import vbd_pkg::*;

    logic [REM_W-1:0]     rem_reg  [0:ROOT_BITS-1];
    logic [PROD_W-1:0]    prod_reg [0:ROOT_BITS-1];
    logic [SQ_W-1:0]      n_reg    [0:ROOT_BITS-1];
    logic [ROOT_BITS-1:0] t_reg    [0:ROOT_BITS-1];
    logic                 neg_reg  [0:ROOT_BITS-1];
    logic                 mz_reg   [0:ROOT_BITS-1];

    for (genvar j = 0; j < ROOT_BITS; j++)
    begin : g_stage
        localparam int B = ROOT_BITS - 1 - j;
        logic [REM_W-1:0]     rem_in, delta, rem_next;
        logic [PROD_W-1:0]    prod_in, prod_next;
        logic [SQ_W-1:0]      n_in;
        logic [ROOT_BITS-1:0] t_in, t_next;
        logic                 neg_in, mz_in, take;

        if (j == 0)
        begin : g_first
            assign rem_in  = {{(REM_W-SQ_W){1'b0}}, sq} << 30;
            assign prod_in = '0;
            assign n_in    = nrm;
            assign t_in    = '0;
            assign neg_in  = neg;
            assign mz_in   = mzero;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[j-1];
            assign prod_in = prod_reg[j-1];
            assign n_in    = n_reg[j-1];
            assign t_in    = t_reg[j-1];
            assign neg_in  = neg_reg[j-1];
            assign mz_in   = mz_reg[j-1];
        end

        always_comb
        begin
            delta = ({{(REM_W-PROD_W){1'b0}}, prod_in} << (B + 1))
                  + ({{(REM_W-SQ_W){1'b0}}, n_in} << (2 * B));
            take = (delta <= rem_in);
            rem_next  = take ? rem_in - delta : rem_in;
            prod_next = take ? prod_in + ({{(PROD_W-SQ_W){1'b0}}, n_in} << B) : prod_in;
            t_next    = take ? (t_in | (ROOT_BITS'(1) << B)) : t_in;
        end

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                rem_reg[j]  <= rem_next;
                prod_reg[j] <= prod_next;
                n_reg[j]    <= n_in;
                t_reg[j]    <= t_next;
                neg_reg[j]  <= neg_in;
                mz_reg[j]   <= mz_in;
            end
        end
    end

    assign root      = t_reg[ROOT_BITS-1];
    assign root_neg  = neg_reg[ROOT_BITS-1];
    assign root_zero = mz_reg[ROOT_BITS-1];

endmodule

`default_nettype wire

FILE: design/view_basis_from_direction_core.sv
// ----------------------------------------------------------------------------
// view_basis_from_direction_core: look-at camera basis
// Unit right and up vectors (Q1.14) from a Q4.12 view direction.
// ----------------------------------------------------------------------------
// One direction beat enters per clock while in_stall is low. In the pipe,
// four stages form the cross products, squares and squared lengths, sixteen
// stages resolve one bit each of the correctly rounded component quotients in
// six parallel root lanes, and one output register rounds and restores signs.
// Bubbles in the pipe close up while the output is stalled.
`default_nettype none

module view_basis_from_direction_core
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire vbd_pkg::dir_t in_data,
    output logic               out_valid,
    input  wire logic          out_stall,
    output vbd_pkg::basis_t    out_data,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import vbd_pkg::*;

    logic invert_up_reg;
    logic [NUM_STAGES:1] v_reg;
    logic [NUM_STAGES:1] en;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_INVERT_UP) ? {31'b0, invert_up_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            invert_up_reg <= 1'b0;
        else if (psel && penable && pwrite && paddr[2] == REG_INVERT_UP)
            invert_up_reg <= pwdata[0];
    end

    assign en[NUM_STAGES] = ~v_reg[NUM_STAGES] | ~out_stall;
    for (genvar i = 1; i < NUM_STAGES; i++)
    begin : g_en
        assign en[i] = ~v_reg[i] | en[i+1];
    end
    assign in_stall  = ~en[1];
    assign out_valid = v_reg[NUM_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[1])
                v_reg[1] <= in_valid;
            for (int i = 2; i <= NUM_STAGES; i++)
            begin
                if (en[i])
                    v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // stage 1: products
    logic signed [31:0] pxx_reg, pzz_reg, pyy_reg, pxy_reg, pyz_reg;
    logic signed [15:0] dx_reg, dy_reg, dz_reg;
    logic               sneg_reg, fb_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            pxx_reg  <= in_data.dir_x * in_data.dir_x;
            pzz_reg  <= in_data.dir_z * in_data.dir_z;
            pyy_reg  <= in_data.dir_y * in_data.dir_y;
            pxy_reg  <= in_data.dir_x * in_data.dir_y;
            pyz_reg  <= in_data.dir_y * in_data.dir_z;
            dx_reg   <= in_data.dir_x;
            dy_reg   <= in_data.dir_y;
            dz_reg   <= in_data.dir_z;
            sneg_reg <= invert_up_reg && (in_data.dir_x > 16'sd0);
            fb_reg   <= (in_data.dir_x == 16'sd0) && (in_data.dir_z == 16'sd0);
        end
    end

    // stage 2: sign and magnitude of right and up
    logic [MAG_W-1:0] mag_next [0:5];
    logic [5:0]       neg_next;
    logic [MAG_W-1:0] mag_reg  [0:5];
    logic [5:0]       neg2_reg;
    logic [15:0]      adx, ady, adz;

    always_comb
    begin
        adx = dx_reg[15] ? 16'(-dx_reg) : 16'(dx_reg);
        ady = dy_reg[15] ? 16'(-dy_reg) : 16'(dy_reg);
        adz = dz_reg[15] ? 16'(-dz_reg) : 16'(dz_reg);
        for (int i = 0; i < 6; i++)
            mag_next[i] = '0;
        neg_next = '0;
        if (fb_reg)
        begin
            mag_next[0] = {16'b0, ady};
            neg_next[0] = ~dy_reg[15];
            mag_next[5] = 32'(pyy_reg);
        end
        else
        begin
            mag_next[0] = {16'b0, adz};
            neg_next[0] = dz_reg[15] ^ sneg_reg;
            mag_next[2] = {16'b0, adx};
            neg_next[2] = (dx_reg[15] == sneg_reg);
            mag_next[3] = pxy_reg[31] ? 32'(-pxy_reg) : 32'(pxy_reg);
            neg_next[3] = (pxy_reg[31] == sneg_reg);
            mag_next[4] = 32'(pxx_reg) + 32'(pzz_reg);
            neg_next[4] = sneg_reg;
            mag_next[5] = pyz_reg[31] ? 32'(-pyz_reg) : 32'(pyz_reg);
            neg_next[5] = (pyz_reg[31] == sneg_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            mag_reg  <= mag_next;
            neg2_reg <= neg_next;
        end
    end

    // stage 3: squares
    logic [SQ_W-1:0] sq_reg [0:5];
    logic [5:0]      neg3_reg, mz3_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int i = 0; i < 6; i++)
            begin
                sq_reg[i]  <= {32'b0, mag_reg[i]} * {32'b0, mag_reg[i]};
                mz3_reg[i] <= (mag_reg[i] == '0);
            end
            neg3_reg <= neg2_reg;
        end
    end

    // stage 4: squared lengths
    logic [SQ_W-1:0] sq4_reg [0:5];
    logic [SQ_W-1:0] nr_reg, nu_reg;
    logic [5:0]      neg4_reg, mz4_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            nr_reg   <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            nu_reg   <= sq_reg[3] + sq_reg[4] + sq_reg[5];
            sq4_reg  <= sq_reg;
            neg4_reg <= neg3_reg;
            mz4_reg  <= mz3_reg;
        end
    end

    // root lanes and output rounding
    logic [ROOT_BITS-1:0] root [0:5];
    logic [5:0]           rneg, rzero;
    logic signed [15:0]   q_next [0:5];
    logic signed [15:0]   q_reg  [0:5];

    for (genvar c = 0; c < 6; c++)
    begin : g_lane
        logic [ROOT_BITS:0] rsum;

        vbd_root_lane u_lane
        (
            .clk       (clk),
            .en        (en[FRONT_STAGES+ROOT_BITS:FRONT_STAGES+1]),
            .sq        (sq4_reg[c]),
            .nrm       ((c < 3) ? nr_reg : nu_reg),
            .neg       (neg4_reg[c]),
            .mzero     (mz4_reg[c]),
            .root      (root[c]),
            .root_neg  (rneg[c]),
            .root_zero (rzero[c])
        );

        assign rsum = {1'b0, root[c]} + 1'b1;
        always_comb
        begin
            if (rzero[c])
                q_next[c] = '0;
            else if (rneg[c])
                q_next[c] = -$signed(rsum[ROOT_BITS:1]);
            else
                q_next[c] = $signed(rsum[ROOT_BITS:1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NUM_STAGES])
            q_reg <= q_next;
    end

    assign out_data.right_x = q_reg[0];
    assign out_data.right_y = q_reg[1];
    assign out_data.right_z = q_reg[2];
    assign out_data.up_x    = q_reg[3];
    assign out_data.up_y    = q_reg[4];
    assign out_data.up_z    = q_reg[5];

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for view_basis_from_direction_core
// Drives direction beats in bursts, predicts the unit right and up vectors
// with exact rounding, and compares every output beat in order. The
// invert_up register is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import vbd_pkg::*;

    localparam int LIMIT_CYCLES = 300000;
    localparam int PIPE_DEPTH   = NUM_STAGES + 10;
    localparam int SPARE_REG    = 1;
    localparam int ONE_Q14      = 16384;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    dir_t        in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    basis_t      out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    dir_t   pending_dirs[$];
    basis_t expected_basis[$];
    logic   invert_up_cfg = 1'b0;
    int     errors = 0;
    int     cycles = 0;
    int     gap_left = 0;
    int     burst_left = 0;
    int     stall_mode = 0;
    int     mode_left = 0;
    int     hold_left = 0;
    logic   hold_req = 1'b0;
    logic   hold_taken = 1'b0;

    view_basis_from_direction_core dut (.*);

    always #5 clk = ~clk;

    function automatic logic signed [15:0] unit_component(longint vi, longint unsigned n);
        longint unsigned m;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned t;
        logic [127:0]    rhs;
        logic [127:0]    lhs;
        m = (vi < 0) ? longint'(-vi) : longint'(vi);
        if (n == 0 || m == 0)
            return '0;
        rhs = 128'(m * m) << 30;
        lo = 0;
        hi = ONE_Q14;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            t = 2 * mid - 1;
            lhs = 128'(t * t) * 128'(n);
            if (lhs <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return (vi < 0) ? -16'(lo) : 16'(lo);
    endfunction

    function automatic longint unsigned sq_len(longint a, longint b, longint c);
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned mc;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        mc = (c < 0) ? -c : c;
        return ma * ma + mb * mb + mc * mc;
    endfunction

    function automatic basis_t camera_basis(dir_t d, logic inv);
        longint dx;
        longint dy;
        longint dz;
        longint s;
        longint r0;
        longint r2;
        longint u0;
        longint u1;
        longint u2;
        longint unsigned nr;
        longint unsigned nu;
        basis_t b;
        dx = d.dir_x;
        dy = d.dir_y;
        dz = d.dir_z;
        s = (inv && dx > 0) ? -1 : 1;
        if (dx != 0 || dz != 0)
        begin
            r0 = s * dz;
            r2 = -s * dx;
            u0 = -s * dx * dy;
            u1 = s * (dx * dx + dz * dz);
            u2 = -s * dy * dz;
        end
        else
        begin
            r0 = -dy;
            r2 = 0;
            u0 = 0;
            u1 = 0;
            u2 = dy * dy;
        end
        nr = sq_len(r0, 0, r2);
        nu = sq_len(u0, u1, u2);
        b.right_x = unit_component(r0, nr);
        b.right_y = '0;
        b.right_z = unit_component(r2, nr);
        b.up_x    = unit_component(u0, nu);
        b.up_y    = unit_component(u1, nu);
        b.up_z    = unit_component(u2, nu);
        return b;
    endfunction

    // sender: bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_dirs.size() > 0)
            begin
                in_data  <= pending_dirs.pop_front();
                in_valid <= 1'b1;
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(40, 0);
                    gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_req && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left  <= 300;
            out_stall  <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(2, 0);
                mode_left  <= $urandom_range(80, 10);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(1, 0) == 0);
                default: out_stall <= ($urandom_range(9, 0) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            expected_basis.push_back(camera_basis(in_data, invert_up_cfg));
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_basis.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat: %p", out_data);
            end
            else
            begin
                basis_t want;
                want = expected_basis.pop_front();
                if (want.right_x !== out_data.right_x || want.right_y !== out_data.right_y ||
                    want.right_z !== out_data.right_z || want.up_x !== out_data.up_x ||
                    want.up_y !== out_data.up_y || want.up_z !== out_data.up_z)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %p got %p", want, out_data);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic reg_write(int idx, logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(idx * 4);
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_INVERT_UP)
            invert_up_cfg = val[0];
    endtask

    task automatic add_dir(int x, int y, int z);
        dir_t d;
        d.dir_x = 16'(x);
        d.dir_y = 16'(y);
        d.dir_z = 16'(z);
        pending_dirs.push_back(d);
    endtask

    task automatic add_directed();
        add_dir(0, 0, 0);
        add_dir(0, 1, 0);
        add_dir(0, -1, 0);
        add_dir(0, 32767, 0);
        add_dir(0, -32768, 0);
        add_dir(32767, 0, 0);
        add_dir(-32768, 0, 0);
        add_dir(0, 0, 32767);
        add_dir(0, 0, -32768);
        add_dir(1, 0, 0);
        add_dir(-1, 0, 0);
        add_dir(0, 0, 1);
        add_dir(32767, 32767, 32767);
        add_dir(-32768, -32768, -32768);
        add_dir(32767, -32768, 32767);
        add_dir(-32768, 32767, -32768);
        add_dir(1, -32768, 1);
        add_dir(-1, 32767, -1);
        add_dir(4096, 4096, -4096);
        add_dir(3, 0, -4);
        add_dir(-1, -1, -1);
    endtask

    task automatic add_random(int count);
        int kind;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(9, 0);
            if (kind < 6)
                add_dir($urandom, $urandom, $urandom);
            else if (kind < 8)
                add_dir($urandom_range(16, 0) - 8, $urandom_range(16, 0) - 8,
                        $urandom_range(16, 0) - 8);
            else if (kind == 8)
                add_dir(0, $urandom, 0);
            else
                add_dir($urandom_range(1, 0) ? $urandom : 0, $urandom,
                        $urandom_range(1, 0) ? 0 : $urandom);
        end
    endtask

    task automatic drain();
        wait (pending_dirs.size() == 0);
        @(posedge clk);
        while (in_valid || expected_basis.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH) @(posedge clk);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        add_directed();
        add_random(280);
        drain();

        reg_write(REG_INVERT_UP, 32'h1);
        add_directed();
        add_random(150);
        @(posedge clk);
        hold_req <= 1'b1;
        add_random(150);
        drain();

        reg_write(SPARE_REG, 32'h0);
        add_directed();
        add_random(60);
        drain();

        reg_write(REG_INVERT_UP, 32'hFFFF_FFFE);
        add_random(150);
        drain();

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

FILE: view_basis_from_direction_core.f
design/vbd_pkg.sv
design/vbd_root_lane.sv
design/view_basis_from_direction_core.sv
tb/tb_top.sv
